// File: rtl/core/rrlm_pkg.sv
// Package with shared types and constants of the request/response latency matcher.
package rrlm_pkg;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned CFG_W  = 40;

    localparam logic [CFG_W-1:0] MAX_LAT_RESET = 40'd60000000000;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 40'd30000000000;

    // Register indexes of the configuration port.
    localparam logic [0:0] CFG_MAX_LATENCY = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT     = 1'b1;

    // SOME/IP message type bytes.
    localparam logic [7:0] MT_REQUEST           = 8'h00;
    localparam logic [7:0] MT_REQUEST_NO_RETURN = 8'h01;
    localparam logic [7:0] MT_NOTIFICATION      = 8'h02;
    localparam logic [7:0] MT_REQUEST_ACK       = 8'h40;
    localparam logic [7:0] MT_RESPONSE          = 8'h80;
    localparam logic [7:0] MT_ERROR             = 8'h81;

    typedef enum logic [3:0] {
        ST_IGNORED   = 4'd0,
        ST_RECORDED  = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_FULL      = 4'd3,
        ST_MATCHED   = 4'd4,
        ST_NOMATCH   = 4'd5,
        ST_TOOOLD    = 4'd6,
        ST_EVICTED   = 4'd7,
        ST_DONE      = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        CL_REQUEST   = 3'd0,
        CL_NORETURN  = 3'd1,
        CL_NOTIF     = 3'd2,
        CL_ACK       = 3'd3,
        CL_RESPONSE  = 3'd4,
        CL_OTHER     = 3'd5,
        CL_NONE      = 3'd6
    } class_t;

    // Operation decided by the front end.
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_RECORD = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        class_t            cls;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] t;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        class_t            cls;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] elapsed;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_SCAN,
        BE_DECIDE,
        BE_TICK_CALC,
        BE_TICK_NEXT,
        BE_EMIT
    } be_state_t;

    function automatic class_t classify(input logic [7:0] mt);
        class_t c;
        priority case (mt)
            MT_REQUEST:           c = CL_REQUEST;
            MT_REQUEST_NO_RETURN: c = CL_NORETURN;
            MT_NOTIFICATION:      c = CL_NOTIF;
            MT_REQUEST_ACK:       c = CL_ACK;
            MT_RESPONSE:          c = CL_RESPONSE;
            default:              c = CL_OTHER;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/rrlm_front.sv
// Front end: accepts input beats, classifies them and queues commands.
module rrlm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic              direction,
    input  logic              is_return,
    input  logic [7:0]        msg_type,
    input  logic [63:0]       key,
    input  logic [63:0]       time_ns,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output rrlm_pkg::cmd_t    cmd
);
    import rrlm_pkg::*;

    cmd_t   q_reg [2];
    logic   wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t   c;
    class_t cl;
    logic   push, pop;

    // Classify the incoming beat.
    always_comb begin
        cl = classify(msg_type);
        c.key = key;
        c.t   = time_ns;
        c.cls = cl;
        c.op  = OP_REPORT;
        if (kind) begin
            c.op  = OP_TICK;
            c.cls = CL_NONE;
        end else if (is_return) begin
            c.cls = CL_NONE;
        end else if (!direction &&
                     (msg_type == MT_REQUEST || msg_type == MT_REQUEST_NO_RETURN)) begin
            c.op = OP_RECORD;
        end else if (direction && (msg_type == MT_RESPONSE ||
                     msg_type == MT_ERROR || msg_type == MT_NOTIFICATION)) begin
            c.op = OP_LOOKUP;
        end
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Two-entry command queue.
    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= c;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/core/rrlm_back.sv
// Back end: table search, update, tick walk and result register.
module rrlm_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rrlm_pkg::cmd_t    cmd,
    input  logic [39:0]       max_latency,
    input  logic [39:0]       timeout,
    output logic              res_valid,
    input  logic              res_ready,
    output rrlm_pkg::res_t    res
);
    import rrlm_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    be_state_t state_reg, state_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];
    cmd_t cmd_reg, cmd_next;
    logic [DEPTH-1:0] hit_reg, hit_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [TIME_W-1:0] diff_reg, diff_next;
    res_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    logic wr_en;
    logic [IW-1:0] wr_idx;

    logic hit_any, free_any;
    logic [IW-1:0] hit_idx, free_idx;

    // Pick matching and free slots from registered compare vectors.
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign cmd_ready = (state_reg == BE_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cmd_next       = cmd_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        diff_next      = diff_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_idx         = free_idx;
        if (out_valid_reg && res_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            BE_IDLE: begin
                if (cmd_valid && !out_valid_reg) begin
                    cmd_next = cmd;
                    idx_next = '0;
                    unique case (cmd.op)
                        OP_TICK: state_next = BE_TICK_CALC;
                        OP_REPORT: begin
                            res_next = '{ST_IGNORED, cmd.cls, cmd.key, '0, 1'b1};
                            out_valid_next = 1'b1;
                        end
                        default: state_next = BE_SCAN;
                    endcase
                end
            end
            // Parallel key compare, registered.
            BE_SCAN: begin
                for (int i = 0; i < DEPTH; i++)
                    hit_next[i] = valid_reg[i] && (key_mem[i] == cmd_reg.key);
                state_next = BE_DECIDE;
            end
            BE_DECIDE: begin
                res_next = '{ST_IGNORED, cmd_reg.cls, cmd_reg.key, '0, 1'b1};
                if (cmd_reg.op == OP_RECORD) begin
                    if (hit_any) begin
                        res_next.status = ST_DUPLICATE;
                    end else if (!free_any) begin
                        res_next.status = ST_FULL;
                    end else begin
                        res_next.status = ST_RECORDED;
                        wr_en = 1'b1;
                        valid_next[free_idx] = 1'b1;
                    end
                    state_next = BE_IDLE;
                    out_valid_next = 1'b1;
                end else if (!hit_any) begin
                    res_next.status = ST_NOMATCH;
                    state_next = BE_IDLE;
                    out_valid_next = 1'b1;
                end else begin
                    diff_next = cmd_reg.t - time_mem[hit_idx];
                    valid_next[hit_idx] = 1'b0;
                    state_next = BE_EMIT;
                end
            end
            BE_EMIT: begin
                res_next = '{ST_MATCHED, cmd_reg.cls, cmd_reg.key, diff_reg, 1'b1};
                if (diff_reg > {24'd0, max_latency}) begin
                    res_next.status  = ST_TOOOLD;
                    res_next.elapsed = '0;
                end
                out_valid_next = 1'b1;
                state_next = BE_IDLE;
            end
            // Tick walk: one slot's age per pass.
            BE_TICK_CALC: begin
                if (!out_valid_reg) begin
                    diff_next  = cmd_reg.t - time_mem[idx_reg];
                    state_next = BE_TICK_NEXT;
                end
            end
            BE_TICK_NEXT: begin
                if (valid_reg[idx_reg] && diff_reg > {24'd0, timeout}) begin
                    res_next = '{ST_EVICTED, CL_NONE, key_mem[idx_reg], diff_reg, 1'b0};
                    out_valid_next = 1'b1;
                    valid_next[idx_reg] = 1'b0;
                end
                if (32'(idx_reg) == DEPTH - 1) begin
                    state_next = BE_IDLE;
                    if (!out_valid_next)
                        res_next = '{ST_DONE, CL_NONE, '0, '0, 1'b1};
                    // Done beat follows an eviction from the last slot.
                    state_next = out_valid_next ? BE_TICK_CALC : BE_IDLE;
                    if (!out_valid_next) out_valid_next = 1'b1;
                    else idx_next = idx_reg;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = BE_TICK_CALC;
                end
            end
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_idx]  <= cmd_reg.key;
            time_mem[wr_idx] <= cmd_reg.t;
        end
        cmd_reg  <= cmd_next;
        hit_reg  <= hit_next;
        idx_reg  <= idx_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: rtl/core/request_response_latency_matcher.sv
// Top level of the SOME/IP request/response latency matcher.
//  Channel | Direction | tdata (low bit up)                               | tuser / tlast
//  s_      | in        | direction, is_return, msg type, service,         | tuser: kind
//          |           | method, client, session, time_ns (pad)           |
//  m_      | out       | status, type_class, entry_key, elapsed_ns (pad)  | tlast: last
//  cfg     | in        | cfg_wdata: 40-bit register value                 | cfg_index
// A message beat waits in the command queue; the back end then takes it, compares
// keys and decides before a record or lookup result is registered; a match passes
// through BE_EMIT as well, which adds the latency compare.
// An ignored beat's result is registered as soon as the back end takes it.
// A tick walks the table one slot per BE_TICK_CALC/BE_TICK_NEXT pass, repeats the pass
// for the last slot after evicting it, and stalls while a result waits for m_tready.
// Reset clears the table valid bits and loads the register defaults.
// A two-entry command queue lets the input side run while the back end stalls.
module request_response_latency_matcher #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // direction, is_return, msg type, service, method,
    // client, session, time_ns, zero pad
    input  logic [143:0] s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, type_class, entry_key, elapsed_ns, zero pad
    output logic [135:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wen,
    input  logic [0:0]   cfg_index,
    input  logic [39:0]  cfg_wdata
);
    import rrlm_pkg::*;

    logic [39:0] max_lat_reg, timeout_reg;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;
    logic [63:0] key;

    assign key = {s_tdata[25:10], s_tdata[41:26], s_tdata[57:42], s_tdata[73:58]};

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lat_reg <= MAX_LAT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wen) begin
            if (cfg_index == CFG_MAX_LATENCY) max_lat_reg <= cfg_wdata;
            if (cfg_index == CFG_TIMEOUT)     timeout_reg <= cfg_wdata;
        end
    end

    rrlm_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .kind(s_tuser), .direction(s_tdata[0]), .is_return(s_tdata[1]),
        .msg_type(s_tdata[9:2]), .key(key), .time_ns(s_tdata[137:74]),
        .cmd_valid, .cmd_ready, .cmd
    );

    rrlm_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .max_latency(max_lat_reg), .timeout(timeout_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {1'b0, res.elapsed, res.key, res.cls, res.status};
    assign m_tlast = res.last;

    // A done beat is always the last beat of its item.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ST_DONE |-> m_tlast)
        else $error("done beat without tlast");
    // A result beat stalls without change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // Evicted beats never close an item.
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ST_EVICTED |-> !m_tlast)
        else $error("eviction marked last");
endmodule

// File: dv/rrlm_checker.sv
// Checker that predicts the latency matcher's results and compares them beat by beat.
`timescale 1ns / 100ps
module rrlm_checker #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tlast,
    input  logic         cfg_wen,
    input  logic [0:0]   cfg_index,
    input  logic [39:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);
    import rrlm_pkg::*;

    // Shadow copy of the registers and the pending-request table.
    logic [CFG_W-1:0]  max_latency;
    logic [CFG_W-1:0]  timeout;
    logic              slot_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]  slot_key [TABLE_DEPTH];
    logic [TIME_W-1:0] slot_sent [TABLE_DEPTH];
    res_t              expected_results [$];

    function automatic res_t make_result(status_t st, class_t cl, logic [63:0] key,
                                         logic [63:0] el, logic lst);
        res_t r;
        r.status  = st;
        r.cls     = cl;
        r.key     = key;
        r.elapsed = el;
        r.last    = lst;
        return r;
    endfunction

    // Append one expected beat at the tail of the queue.
    function automatic void add_expected(res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic class_t class_of(logic [7:0] mt);
        class_t c;
        unique case (mt)
            MT_REQUEST:           c = CL_REQUEST;
            MT_REQUEST_NO_RETURN: c = CL_NORETURN;
            MT_NOTIFICATION:      c = CL_NOTIF;
            MT_REQUEST_ACK:       c = CL_ACK;
            MT_RESPONSE:          c = CL_RESPONSE;
            default:              c = CL_OTHER;
        endcase
        return c;
    endfunction

    // Work out the results of one accepted input beat and update the table.
    task automatic predict_latency_event(logic kind, logic [143:0] d);
        logic              dir;
        logic              ret;
        logic [7:0]        mt;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] age;
        class_t            cl;
        int                hit;
        int                free_slot;
        dir = d[0];
        ret = d[1];
        mt  = d[9:2];
        key = {d[25:10], d[41:26], d[57:42], d[73:58]};
        t   = d[137:74];
        hit = -1;
        free_slot = -1;
        if (kind) begin
            // A tick evicts stale entries in slot order, then closes with a done beat.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                age = t - slot_sent[i];
                if (slot_valid[i] && age > {24'd0, timeout}) begin
                    add_expected(make_result(ST_EVICTED, CL_NONE, slot_key[i], age, 1'b0));
                    slot_valid[i] = 1'b0;
                end
            end
            add_expected(make_result(ST_DONE, CL_NONE, '0, '0, 1'b1));
            return;
        end
        if (ret) begin
            add_expected(make_result(ST_IGNORED, CL_NONE, key, '0, 1'b1));
            return;
        end
        cl = class_of(mt);
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_key[i] == key) hit = i;
            if (!slot_valid[i]) free_slot = i;
        end
        if (!dir && (mt == MT_REQUEST || mt == MT_REQUEST_NO_RETURN)) begin
            if (hit >= 0) begin
                add_expected(make_result(ST_DUPLICATE, cl, key, '0, 1'b1));
            end else if (free_slot < 0) begin
                add_expected(make_result(ST_FULL, cl, key, '0, 1'b1));
            end else begin
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot]   = key;
                slot_sent[free_slot]  = t;
                add_expected(make_result(ST_RECORDED, cl, key, '0, 1'b1));
            end
        end else if (dir && (mt == MT_RESPONSE || mt == MT_ERROR || mt == MT_NOTIFICATION)) begin
            if (hit < 0) begin
                add_expected(make_result(ST_NOMATCH, cl, key, '0, 1'b1));
            end else begin
                age = t - slot_sent[hit];
                slot_valid[hit] = 1'b0;
                if (age > {24'd0, max_latency})
                    add_expected(make_result(ST_TOOOLD, cl, key, '0, 1'b1));
                else
                    add_expected(make_result(ST_MATCHED, cl, key, age, 1'b1));
            end
        end else begin
            add_expected(make_result(ST_IGNORED, cl, key, '0, 1'b1));
        end
    endtask

    // Compare one delivered result beat with the oldest expectation.
    task automatic check_result(logic [135:0] d, logic lst);
        res_t got;
        res_t want;
        got = make_result(status_t'(d[3:0]), class_t'(d[6:4]), d[70:7], d[134:71], lst);
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: unexpected result beat status=%0d key=%h", got.status, got.key);
            return;
        end
        want = expected_results.pop_front();
        if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("ERROR: result mismatch");
                $display("  exp status=%0d cls=%0d key=%h el=%h last=%b",
                         want.status, want.cls, want.key, want.elapsed, want.last);
                $display("  act status=%0d cls=%0d key=%h el=%h last=%b",
                         got.status, got.cls, got.key, got.elapsed, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_latency = MAX_LAT_RESET;
            timeout     = TIMEOUT_RESET;
            fail_count  = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_valid[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_wen) begin
                if (cfg_index == CFG_MAX_LATENCY) max_latency = cfg_wdata;
                else if (cfg_index == CFG_TIMEOUT) timeout = cfg_wdata;
            end
            if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready) predict_latency_event(s_tuser, s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

// File: dv/request_response_latency_matcher_tb.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the latency matcher.
`timescale 1ns / 100ps
module request_response_latency_matcher_tb;
    import rrlm_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     POOL_SIZE      = 20;
    localparam logic [39:0] CFG_MAX   = 40'hFF_FFFF_FFFF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;
    logic         cfg_wen;
    logic [0:0]   cfg_index;
    logic [39:0]  cfg_wdata;
    int           fail_count;
    int           pending;

    logic         quiet;
    logic         hold_off_req;
    logic [63:0]  now_ns;
    logic [63:0]  key_pool [POOL_SIZE];
    int           idle_cycles;

    request_response_latency_matcher DUT (.*);

    rrlm_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Send one input beat, with a random gap ahead of it unless the run is quiet.
    task automatic send_beat(logic kind, logic dir, logic ret, logic [7:0] mt,
                             logic [63:0] key, logic [63:0] t);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {6'd0, t, key[15:0], key[31:16], key[47:32], key[63:48], mt, ret, dir};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [0:0] idx, logic [39:0] value);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wen   = 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending == 0);
        repeat (60) @(posedge aclk);
    endtask

    // Mostly well-formed request/answer traffic over a small key pool, some noise.
    task automatic random_traffic(int count);
        logic [63:0] key;
        int          pick;
        for (int n = 0; n < count; n++) begin
            now_ns += $urandom_range(0, 3000);
            if ($urandom_range(0, 7) == 0) now_ns += {28'd0, 4'($urandom), 32'd0};
            key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_beat(1'b0, 1'b0, 1'b0, $urandom_range(0, 1) ? MT_REQUEST
                          : MT_REQUEST_NO_RETURN, key, now_ns);
            else if (pick < 14)
                send_beat(1'b0, 1'b1, 1'b0, pick == 8 ? MT_NOTIFICATION
                          : pick < 11 ? MT_ERROR : MT_RESPONSE, key, now_ns);
            else if (pick < 16)
                send_beat(1'b1, 1'($urandom), 1'($urandom), 8'($urandom), 64'd0, now_ns);
            else
                send_beat(1'($urandom_range(0, 4) == 0), 1'($urandom), 1'($urandom),
                          8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready = 1'b1;
            end else if (!quiet && aresetn && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end else begin
                m_tready = aresetn;
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = CFG_MAX_LATENCY;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        now_ns       = 64'd1000;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: probes, ignored kinds, full table, every answer kind.
        send_beat(1'b0, 1'b1, 1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(1'b0, 1'b0, 1'b0, MT_REQUEST_ACK, 64'd0, 64'd0);
        send_beat(1'b0, 1'b1, 1'b0, MT_REQUEST, key_pool[0], 64'd5);
        for (int i = 0; i < 16; i++)
            send_beat(1'b0, 1'b0, 1'b0, i[0] ? MT_REQUEST_NO_RETURN : MT_REQUEST,
                      key_pool[i], 64'd100 + i);
        send_beat(1'b0, 1'b0, 1'b0, MT_REQUEST, key_pool[16], 64'd200);
        send_beat(1'b0, 1'b0, 1'b0, MT_REQUEST, key_pool[0], 64'd201);
        send_beat(1'b0, 1'b1, 1'b0, MT_RESPONSE, key_pool[0], 64'd1100);
        send_beat(1'b0, 1'b1, 1'b0, MT_ERROR, key_pool[1], 64'd50);
        send_beat(1'b0, 1'b1, 1'b0, MT_NOTIFICATION, key_pool[2], 64'd3000);
        send_beat(1'b0, 1'b1, 1'b0, MT_RESPONSE, key_pool[17], 64'd3000);
        send_beat(1'b0, 1'b1, 1'b0, MT_RESPONSE, key_pool[3], 64'd60000000104);
        send_beat(1'b1, 1'b0, 1'b0, 8'h00, 64'd0, 64'd20000000000);
        send_beat(1'b1, 1'b0, 1'b0, 8'h00, 64'd0, 64'd0);

        // Reset register values, with the long receiver hold-off in the middle.
        random_traffic(20);
        hold_off_req = 1'b1;
        random_traffic(20);
        wait_drained();

        // Tight latency limit, loosest timeout.
        write_reg(CFG_MAX_LATENCY, 40'd1);
        write_reg(CFG_TIMEOUT, CFG_MAX);
        random_traffic(20);
        wait_drained();

        // Loosest latency limit, tightest timeout.
        write_reg(CFG_MAX_LATENCY, CFG_MAX);
        write_reg(CFG_TIMEOUT, 40'd1);
        random_traffic(20);
        wait_drained();

        // Mid-range settings, no idling in the final stretch.
        write_reg(CFG_MAX_LATENCY, 40'd2000);
        write_reg(CFG_TIMEOUT, 40'd20000);
        quiet = 1'b1;
        random_traffic(20);
        wait_drained();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: request_response_latency_matcher.f
rtl/core/rrlm_pkg.sv
rtl/core/rrlm_front.sv
rtl/core/rrlm_back.sv
rtl/core/request_response_latency_matcher.sv
dv/rrlm_checker.sv
dv/request_response_latency_matcher_tb.sv
